FILE: rtl/rwlc_pkg.sv
// ----------------------------------------------------------------------------
// rwlc_pkg - shared types for the rotated window line clipper
// Pipeline word layouts, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package rwlc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_ROT_NEG_SINE    = 3'd0;
    localparam logic [2:0] CFG_ROT_COSINE      = 3'd1;
    localparam logic [2:0] CFG_CENTER_OFFSET_V = 3'd2;
    localparam logic [2:0] CFG_CENTER_OFFSET_U = 3'd3;
    localparam logic [2:0] CFG_WINDOW_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_WINDOW_HEIGHT   = 3'd5;

    // edge terms carry 30 fraction bits, magnitude below 2^50
    localparam int EW = 51;
    localparam int NUM_EDGES = 4;
    // Q16.16 value of one
    localparam logic [16:0] T_ONE = 17'h10000;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } geom_t;

    // one divider lane: partial remainder, divisor and quotient so far
    typedef struct packed {
        logic [EW-1:0] rem;
        logic [EW-1:0] up;
        logic [14:0]   uq_low;
        logic [30:0]   quo;
        logic          sat;
        logic          neg;
        logic          pzero;
        logic          pneg;
        logic          qneg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [NUM_EDGES-1:0] lane;
        geom_t                     geom;
    } div_word_t;

    typedef struct packed {
        logic signed [31:0] r;
        logic               pzero;
        logic               pneg;
        logic               qneg;
    } edge_lane_t;

    typedef struct packed {
        edge_lane_t [NUM_EDGES-1:0] lane;
        geom_t                      geom;
        logic [16:0]                t0;
        logic [16:0]                t1;
        logic                       ok;
    } edge_word_t;

endpackage

FILE: rtl/rwlc_div_cell.sv
// ----------------------------------------------------------------------------
// rwlc_div_cell - one quotient bit of the ratio dividers
// Restoring step on every edge lane, then hands the word on.
// ----------------------------------------------------------------------------
module rwlc_div_cell
    import rwlc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      valid_in,
    input  div_word_t word_in,
    output logic      valid_out,
    output div_word_t word_out
);

    div_word_t word_next;
    logic [NUM_EDGES-1:0] din;

    // next dividend bit: dividend is |q| shifted up by 16
    generate
        if (BIT >= 16)
        begin : g_hi
            always_comb
            begin
                for (int e = 0; e < NUM_EDGES; e++)
                begin
                    din[e] = word_in.lane[e].uq_low[BIT-16];
                end
            end
        end
        else
        begin : g_lo
            assign din = '0;
        end
    endgenerate

    // shift, compare, subtract
    always_comb
    begin
        logic [EW:0] rs;
        logic [EW:0] df;
        word_next = word_in;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            rs = {word_in.lane[e].rem[EW-1:0], din[e]};
            df = rs - {1'b0, word_in.lane[e].up};
            if (!df[EW])
            begin
                word_next.lane[e].rem = df[EW-1:0];
                word_next.lane[e].quo = {word_in.lane[e].quo[29:0], 1'b1};
            end
            else
            begin
                word_next.lane[e].rem = rs[EW-1:0];
                word_next.lane[e].quo = {word_in.lane[e].quo[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (adv)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_out <= word_next;
        end
    end

endmodule

FILE: rtl/rwlc_edge_cell.sv
// ----------------------------------------------------------------------------
// rwlc_edge_cell - one window edge test
// Narrows t0 or t1 with this edge's ratio, or rejects the segment.
// ----------------------------------------------------------------------------
module rwlc_edge_cell
    import rwlc_pkg::*;
#(
    parameter int EDGE = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       valid_in,
    input  edge_word_t word_in,
    output logic       valid_out,
    output edge_word_t word_out
);

    edge_word_t word_next;
    edge_lane_t ln;
    logic signed [31:0] t0s;
    logic signed [31:0] t1s;

    assign ln  = word_in.lane[EDGE];
    assign t0s = $signed({15'd0, word_in.t0});
    assign t1s = $signed({15'd0, word_in.t1});

    // edge test, skipped once the segment is rejected
    always_comb
    begin
        word_next = word_in;
        if (word_in.ok)
        begin
            if (ln.pneg)
            begin
                if (ln.r > t1s)
                    word_next.ok = 1'b0;
                else if (ln.r > t0s)
                    word_next.t0 = ln.r[16:0];
            end
            else if (!ln.pzero)
            begin
                if (ln.r < t0s)
                    word_next.ok = 1'b0;
                else if (ln.r < t1s)
                    word_next.t1 = ln.r[16:0];
            end
            else if (ln.qneg)
            begin
                word_next.ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (adv)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_out <= word_next;
        end
    end

endmodule

FILE: rtl/rotated_window_line_clipper_top.sv
// ----------------------------------------------------------------------------
// rotated_window_line_clipper_top - Liang-Barsky clipper, rotated window
// Clips one Q16.16 segment per cycle against a tilted rectangle, unless the output is held.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one segment word: start and end
//   points. Output channel (out_valid/out_ready) gives one result word per
//   segment: accepted flag and clipped endpoints (zero when rejected).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the user
//   must write it only while no segment is in flight, the block does not enforce it.
//   Throughput is one segment per cycle while the output word is not held. The
//   pipeline is made of six front end stages, the four ratio dividers (a
//   chain of 31 cells that each resolve one quotient bit), the ratio stage,
//   an edge cell per edge, the endpoint multipliers and the output register.
//   The whole pipeline moves as one: when the output word is held by the
//   receiver, every stage holds and in_ready is low.
//   Reset empties the pipeline and loads the register defaults: no tilt,
//   unit cosine, zero centre terms, a 1.0 by 1.0 window.
// ----------------------------------------------------------------------------
module rotated_window_line_clipper_top
    import rwlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic signed [31:0] clip_start_x,
    output logic signed [31:0] clip_start_y,
    output logic signed [31:0] clip_end_x,
    output logic signed [31:0] clip_end_y
);

    localparam int NDIV = 31;

    // configuration registers
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic signed [31:0] cv_reg;
    logic signed [31:0] cu_reg;
    logic [30:0]        w_reg;
    logic [30:0]        h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= '0;
            cos_reg <= 16'sd16384;
            cv_reg  <= '0;
            cu_reg  <= '0;
            w_reg   <= 31'd65536;
            h_reg   <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROT_NEG_SINE:    sin_reg <= cfg_wdata[15:0];
                CFG_ROT_COSINE:      cos_reg <= cfg_wdata[15:0];
                CFG_CENTER_OFFSET_V: cv_reg  <= cfg_wdata;
                CFG_CENTER_OFFSET_U: cu_reg  <= cfg_wdata;
                CFG_WINDOW_WIDTH:    w_reg   <= cfg_wdata[30:0];
                CFG_WINDOW_HEIGHT:   h_reg   <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // global advance: the whole row moves unless the output word is held
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // divider row and edge row links
    logic       div_v [NDIV+1];
    div_word_t  div_w [NDIV+1];
    logic       edge_v [NUM_EDGES+1];
    edge_word_t edge_w [NUM_EDGES+1];

    // valid bits of the front and back stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vr_reg, vm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vr_reg <= 1'b0;
            vm_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vr_reg <= div_v[NDIV];
            vm_reg <= edge_v[NUM_EDGES];
        end
    end

    // stage 1: capture and differences
    geom_t g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg.x0 <= start_x;
            g1_reg.y0 <= start_y;
            g1_reg.dx <= 33'(end_x) - 33'(start_x);
            g1_reg.dy <= 33'(end_y) - 33'(start_y);
        end
    end

    // stage 2: rotation products
    logic signed [48:0] sdy_reg, cdx_reg, sdx_reg, cdy_reg;
    logic signed [48:0] sy0_reg, cx0_reg, sx0_reg, cy0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdy_reg <= sin_reg * g1_reg.dy;
            cdx_reg <= cos_reg * g1_reg.dx;
            sdx_reg <= sin_reg * g1_reg.dx;
            cdy_reg <= cos_reg * g1_reg.dy;
            sy0_reg <= sin_reg * g1_reg.y0;
            cx0_reg <= cos_reg * g1_reg.x0;
            sx0_reg <= sin_reg * g1_reg.x0;
            cy0_reg <= cos_reg * g1_reg.y0;
            g2_reg  <= g1_reg;
        end
    end

    // stage 3: direction and distance sums
    logic signed [EW-1:0] p1_reg, q1_reg, p2_reg, q2_reg;
    logic signed [EW-1:0] cu_term, cv_term, w_half, h_half;

    assign cu_term = EW'($signed({cu_reg, 14'd0}));
    assign cv_term = EW'($signed({cv_reg, 14'd0}));
    assign w_half  = EW'($signed({1'b0, w_reg, 13'd0}));
    assign h_half  = EW'($signed({1'b0, h_reg, 13'd0}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= EW'(sdy_reg) - EW'(cdx_reg);
            q1_reg <= EW'(cx0_reg) - EW'(sy0_reg) - cu_term + w_half;
            p2_reg <= -EW'(sdx_reg) - EW'(cdy_reg);
            q2_reg <= EW'(sx0_reg) + EW'(cy0_reg) + cv_term + h_half;
            g3_reg <= g2_reg;
        end
    end

    // stage 4: p and q of each window edge
    logic signed [EW-1:0] pe_reg [NUM_EDGES];
    logic signed [EW-1:0] qe_reg [NUM_EDGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pe_reg[0] <= p1_reg;
            qe_reg[0] <= q1_reg;
            pe_reg[1] <= -p1_reg;
            qe_reg[1] <= EW'($signed({1'b0, w_reg, 14'd0})) - q1_reg;
            pe_reg[2] <= p2_reg;
            qe_reg[2] <= q2_reg;
            pe_reg[3] <= -p2_reg;
            qe_reg[3] <= EW'($signed({1'b0, h_reg, 14'd0})) - q2_reg;
            g4_reg    <= g3_reg;
        end
    end

    // stage 5: magnitudes and signs
    logic [EW-1:0] uq_reg [NUM_EDGES];
    logic [EW-1:0] up_reg [NUM_EDGES];
    logic [NUM_EDGES-1:0] pneg_reg, qneg_reg, pzero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                uq_reg[e]    <= qe_reg[e][EW-1] ? EW'(-qe_reg[e]) : EW'(qe_reg[e]);
                up_reg[e]    <= pe_reg[e][EW-1] ? EW'(-pe_reg[e]) : EW'(pe_reg[e]);
                pneg_reg[e]  <= pe_reg[e][EW-1];
                qneg_reg[e]  <= qe_reg[e][EW-1];
                pzero_reg[e] <= (pe_reg[e] == '0);
            end
            g5_reg <= g4_reg;
        end
    end

    // stage 6: divider set-up, saturation when the integer part reaches 2^15
    div_word_t d6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                d6_reg.lane[e].sat    <= ({15'd0, uq_reg[e]} >= {up_reg[e], 15'd0});
                d6_reg.lane[e].rem    <= uq_reg[e] >> 15;
                d6_reg.lane[e].up     <= up_reg[e];
                d6_reg.lane[e].uq_low <= uq_reg[e][14:0];
                d6_reg.lane[e].quo    <= '0;
                d6_reg.lane[e].neg    <= pneg_reg[e] ^ qneg_reg[e];
                d6_reg.lane[e].pzero  <= pzero_reg[e];
                d6_reg.lane[e].pneg   <= pneg_reg[e];
                d6_reg.lane[e].qneg   <= qneg_reg[e];
            end
            d6_reg.geom <= g5_reg;
        end
    end

    // divider row: one quotient bit per cell, most significant first
    assign div_v[0] = v6_reg;
    assign div_w[0] = d6_reg;

    generate
        for (genvar k = 0; k < NDIV; k++)
        begin : g_div
            rwlc_div_cell #(
                .BIT (NDIV - 1 - k)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (div_v[k]),
                .word_in   (div_w[k]),
                .valid_out (div_v[k+1]),
                .word_out  (div_w[k+1])
            );
        end
    endgenerate

    // ratio stage: signed, saturated Q16.16
    edge_word_t er_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (div_w[NDIV].lane[e].sat)
                    er_reg.lane[e].r <= div_w[NDIV].lane[e].neg ? 32'sh80000000
                                                                : 32'sh7fffffff;
                else if (div_w[NDIV].lane[e].neg)
                    er_reg.lane[e].r <= -$signed({1'b0, div_w[NDIV].lane[e].quo});
                else
                    er_reg.lane[e].r <= $signed({1'b0, div_w[NDIV].lane[e].quo});
                er_reg.lane[e].pzero <= div_w[NDIV].lane[e].pzero;
                er_reg.lane[e].pneg  <= div_w[NDIV].lane[e].pneg;
                er_reg.lane[e].qneg  <= div_w[NDIV].lane[e].qneg;
            end
            er_reg.geom <= div_w[NDIV].geom;
            er_reg.t0   <= '0;
            er_reg.t1   <= T_ONE;
            er_reg.ok   <= 1'b1;
        end
    end

    // edge row, in the fixed edge order
    assign edge_v[0] = vr_reg;
    assign edge_w[0] = er_reg;

    generate
        for (genvar k = 0; k < NUM_EDGES; k++)
        begin : g_edge
            rwlc_edge_cell #(
                .EDGE (k)
            ) u_edge (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (edge_v[k]),
                .word_in   (edge_w[k]),
                .valid_out (edge_v[k+1]),
                .word_out  (edge_w[k+1])
            );
        end
    endgenerate

    // endpoint products t * d
    logic signed [50:0] t0dx_reg, t0dy_reg, t1dx_reg, t1dy_reg;
    logic signed [31:0] mx0_reg, my0_reg;
    logic               mok_reg;
    edge_word_t         ew;

    assign ew = edge_w[NUM_EDGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0dx_reg <= $signed({1'b0, ew.t0}) * ew.geom.dx;
            t0dy_reg <= $signed({1'b0, ew.t0}) * ew.geom.dy;
            t1dx_reg <= $signed({1'b0, ew.t1}) * ew.geom.dx;
            t1dy_reg <= $signed({1'b0, ew.t1}) * ew.geom.dy;
            mx0_reg  <= ew.geom.x0;
            my0_reg  <= ew.geom.y0;
            mok_reg  <= ew.ok;
        end
    end

    // output word: floor of the product, offset by the start point
    logic signed [50:0] s0x, s0y, s1x, s1y;

    assign s0x = t0dx_reg >>> 16;
    assign s0y = t0dy_reg >>> 16;
    assign s1x = t1dx_reg >>> 16;
    assign s1y = t1dy_reg >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            accepted     <= mok_reg;
            clip_start_x <= mok_reg ? mx0_reg + s0x[31:0] : '0;
            clip_start_y <= mok_reg ? my0_reg + s0y[31:0] : '0;
            clip_end_x   <= mok_reg ? mx0_reg + s1x[31:0] : '0;
            clip_end_y   <= mok_reg ? my0_reg + s1y[31:0] : '0;
        end
    end

    // checks
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> clip_start_x == 0 && clip_start_y == 0
                                   && clip_end_x == 0 && clip_end_y == 0)
        else $error("rejected word carries non-zero endpoints");

    a_t_order: assert property (@(posedge clk) disable iff (!rst_n)
        edge_v[NUM_EDGES] && ew.ok |-> ew.t0 <= ew.t1 && ew.t1 <= T_ONE)
        else $error("clip parameters out of order");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        div_v[NDIV] && !div_w[NDIV].lane[0].sat && !div_w[NDIV].lane[0].pzero
        |-> div_w[NDIV].lane[0].rem < div_w[NDIV].lane[0].up)
        else $error("divider remainder not below divisor");

endmodule

FILE: bench/rwlc_checker.sv
// ----------------------------------------------------------------------------
// rwlc_checker - result predictor and scoreboard for the line clipper
// Watches the configuration port and both channels. Keeps its own copy of
// the window registers, clips every accepted segment word and compares each
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module rwlc_checker
    import rwlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               accepted,
    input  logic signed [31:0] clip_start_x,
    input  logic signed [31:0] clip_start_y,
    input  logic signed [31:0] clip_end_x,
    input  logic signed [31:0] clip_end_y,
    output int                 fail_count,
    output int                 clips_pending
);

    typedef struct packed {
        logic               hit;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } clip_word_t;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // window registers as the block should hold them
    logic signed [15:0] win_nsin;
    logic signed [15:0] win_cos;
    logic signed [31:0] win_cv;
    logic signed [31:0] win_cu;
    logic [30:0]        win_w;
    logic [30:0]        win_h;

    clip_word_t clip_q[$];

    assign clips_pending = clip_q.size();

    // q/p as Q16.16, magnitude truncated, saturated
    function automatic longint q16_ratio(longint q, longint p);
        logic neg;
        longint unsigned uq, up, ip, rem, mag;
        neg = (q < 0) != (p < 0);
        uq  = (q < 0) ? -q : q;
        up  = (p < 0) ? -p : p;
        ip  = uq / up;
        if (ip >= 64'd32768)
            mag = 64'd1 << 31;
        else
        begin
            rem = uq % up;
            mag = ip;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                mag = mag << 1;
                if (rem >= up)
                begin
                    rem = rem - up;
                    mag = mag | 64'd1;
                end
            end
        end
        if (neg)
            return (mag >= (64'd1 << 31)) ? SAT_LO : -longint'(mag);
        return (mag > 64'd2147483647) ? SAT_HI : longint'(mag);
    endfunction

    // one Liang-Barsky edge; narrows [lo, hi], returns 0 on rejection
    function automatic bit edge_keeps(longint p, longint q, inout longint lo,
                                      inout longint hi);
        longint r;
        if (p < 0)
        begin
            r = q16_ratio(q, p);
            if (r > hi)
                return 1'b0;
            if (r > lo)
                lo = r;
        end
        else if (p > 0)
        begin
            r = q16_ratio(q, p);
            if (r < lo)
                return 1'b0;
            if (r < hi)
                hi = r;
        end
        else if (q < 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic clip_word_t clip_segment(longint x0, longint y0,
                                                longint x1, longint y1);
        longint dx, dy, s, c, lo, hi, p, q, wq, hq;
        bit ok;
        clip_word_t w;
        dx = x1 - x0;
        dy = y1 - y0;
        s  = win_nsin;
        c  = win_cos;
        lo = 0;
        hi = 65536;
        wq = longint'(win_w) * 16384;
        hq = longint'(win_h) * 16384;
        p  = s * dy - c * dx;
        q  = -s * y0 + c * x0 - longint'(win_cu) * 16384 + longint'(win_w) * 8192;
        ok = edge_keeps(p, q, lo, hi) && edge_keeps(-p, wq - q, lo, hi);
        if (ok)
        begin
            p  = -s * dx - c * dy;
            q  = s * x0 + c * y0 + longint'(win_cv) * 16384 + longint'(win_h) * 8192;
            ok = edge_keeps(p, q, lo, hi) && edge_keeps(-p, hq - q, lo, hi);
        end
        w = '0;
        if (ok)
        begin
            // arithmetic shift floors toward minus infinity
            w.hit = 1'b1;
            w.sx  = 32'(x0 + ((lo * dx) >>> 16));
            w.sy  = 32'(y0 + ((lo * dy) >>> 16));
            w.ex  = 32'(x0 + ((hi * dx) >>> 16));
            w.ey  = 32'(y0 + ((hi * dy) >>> 16));
        end
        return w;
    endfunction

    // inputs change only at the rising edge, so the falling edge sees
    // exactly what the next rising edge will take
    always @(negedge clk or negedge rst_n)
    begin
        clip_word_t want, got;
        if (!rst_n)
        begin
            win_nsin   <= 16'sd0;
            win_cos    <= 16'sd16384;
            win_cv     <= '0;
            win_cu     <= '0;
            win_w      <= 31'd65536;
            win_h      <= 31'd65536;
            fail_count <= 0;
            clip_q.delete();
        end
        else
        begin
            // register writes; spare indexes are ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROT_NEG_SINE:    win_nsin <= cfg_wdata[15:0];
                    CFG_ROT_COSINE:      win_cos  <= cfg_wdata[15:0];
                    CFG_CENTER_OFFSET_V: win_cv   <= cfg_wdata;
                    CFG_CENTER_OFFSET_U: win_cu   <= cfg_wdata;
                    CFG_WINDOW_WIDTH:    win_w    <= cfg_wdata[30:0];
                    CFG_WINDOW_HEIGHT:   win_h    <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            // segment word taken
            if (in_valid && in_ready)
                clip_q.push_back(clip_segment(start_x, start_y, end_x, end_y));
            // result word taken
            if (out_valid && out_ready)
            begin
                got = {accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y};
                if (clip_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = clip_q.pop_front();
                    if (want != got)
                    begin
                        if (fail_count < 10)
                            $display("clip mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - regression for the rotated window line clipper
// Writes a series of window settings, from reset values to extremes, and for
// each one sends directed or random segment words, mostly with random gaps and
// output stalls. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import rwlc_pkg::*;

    // index past the last register, must be ignored
    localparam logic [2:0] CFG_SPARE = 3'd6;
    localparam int         Q1 = 65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] start_x = '0;
    logic signed [31:0] start_y = '0;
    logic signed [31:0] end_x = '0;
    logic signed [31:0] end_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               accepted;
    logic signed [31:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;
    int                 fail_count, clips_pending;
    bit                 gaps_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rotated_window_line_clipper_top i_dut (.*);
    rwlc_checker i_checker (.*);

    // receiver stalls
    always @(posedge clk)
        out_ready <= !(gaps_on && $urandom_range(99) < 18);

    initial
    begin
        #2000000;
        $display("rotated_window_line_clipper_top regression: fail");
        $finish;
    end

    // one segment word, held until taken
    task automatic send_segment(logic [31:0] x0, logic [31:0] y0,
                                logic [31:0] x1, logic [31:0] y1);
        if (gaps_on && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= x0;
        start_y  <= y0;
        end_x    <= x1;
        end_y    <= y1;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // wait for every result, then out the pipeline latency
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (clips_pending != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic load_window(logic [31:0] nsin, logic [31:0] cosv,
                               logic [31:0] cv, logic [31:0] cu,
                               logic [31:0] w, logic [31:0] h);
        logic [31:0] vals[6];
        logic [2:0]  idx[6];
        vals = '{nsin, cosv, cv, cu, w, h};
        idx  = '{CFG_ROT_NEG_SINE, CFG_ROT_COSINE, CFG_CENTER_OFFSET_V,
                 CFG_CENTER_OFFSET_U, CFG_WINDOW_WIDTH, CFG_WINDOW_HEIGHT};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        // spare index write should change nothing
        cfg_index <= CFG_SPARE;
        cfg_wdata <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly segments at window scale, some full range
    task automatic random_segments(int n, int span);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
                send_segment($urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span,
                             $urandom_range(2 * span) - span);
            else if (sel < 9)
                send_segment($urandom, $urandom, $urandom, $urandom);
            else
            begin
                // degenerate: point or axis-aligned line
                logic [31:0] a = $urandom_range(2 * span) - span;
                logic [31:0] b = $urandom_range(2 * span) - span;
                send_segment(a, b, $urandom_range(1) ? a : $urandom, b);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset window: unit square centred on the origin
        send_segment(0, 0, 0, 0);                           // point inside
        send_segment(2 * Q1, 0, 2 * Q1, 0);                 // point outside
        send_segment(-2 * Q1, 0, 2 * Q1, 0);                // crosses both sides
        send_segment(0, -2 * Q1, 0, 2 * Q1);                // vertical crossing
        send_segment(-Q1 / 4, -Q1 / 4, Q1 / 4, Q1 / 4);     // fully inside
        send_segment(3 * Q1, 3 * Q1, 4 * Q1, 5 * Q1);       // fully outside
        send_segment(-3 * Q1, 0, 0, 3 * Q1);                // misses corner
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_segment(32'h8000_0000, 0, 32'h8000_0001, 0);   // ratio saturates
        send_segment(-Q1 / 2, -Q1 / 2, Q1 / 2, Q1 / 2);     // diagonal on corners
        send_segment(Q1 / 2, 0, Q1, 0);                     // starts on the edge
        send_segment(0, 32'hffff_ffff, 1, 0);
        send_segment(32'h7fff_ffff, 0, 32'h7fff_ffff, 0);
        drain();

        // settings: rotated, extreme tilts, invalid trig, huge and empty
        load_window(-32'sd11585, 32'sd11585, Q1, -Q1, 4 * Q1, 2 * Q1);
        random_segments(330, 4 * Q1);
        drain();

        gaps_on = 1'b0;
        load_window(-32'sd16384, 0, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff);
        random_segments(330, 32'h4000_0000);
        drain();
        gaps_on = 1'b1;

        load_window(32'h8000, 32'h8000, 0, 0, 0, 0);
        random_segments(330, 2 * Q1);
        drain();

        load_window(16384, -32'sd16384, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff);
        random_segments(330, 32'h7000_0000);
        drain();

        for (int k = 0; k < 2; k++)
        begin
            load_window($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                        $urandom_range(8 * Q1) - 4 * Q1, $urandom_range(8 * Q1) - 4 * Q1,
                        $urandom_range(8 * Q1), $urandom_range(8 * Q1));
            random_segments(330, 6 * Q1);
            drain();
        end

        if (fail_count == 0 && clips_pending == 0)
            $display("rotated_window_line_clipper_top regression: pass");
        else
            $display("rotated_window_line_clipper_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rwlc_pkg.sv
rtl/rwlc_div_cell.sv
rtl/rwlc_edge_cell.sv
rtl/rotated_window_line_clipper_top.sv
bench/rwlc_checker.sv
bench/tb.sv
